// ===== rtl/sha1he_pkg.sv =====
// Shared types, constants and helpers for the SHA-1 hash engine.
package sha1he_pkg;

   localparam int unsigned BlockBytes        = 64;
   localparam int unsigned BlockWords        = 16;
   localparam int unsigned DigestWords       = 5;
   localparam int unsigned RoundCount        = 80;
   localparam int unsigned QueueDepthDefault = 4;
   localparam int unsigned LengthBytePos     = 56;

   localparam logic [2:0] MaxBytes  = 3'd4;
   localparam logic [7:0] PadByte   = 8'h80;
   localparam logic [6:0] LastRound = 7'd79;
   localparam logic [6:0] Stage1End = 7'd20;
   localparam logic [6:0] Stage2End = 7'd40;
   localparam logic [6:0] Stage3End = 7'd60;
   localparam logic [2:0] LastDigestIdx = 3'd4;

   localparam logic [DigestWords-1:0][31:0] InitHash = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [31:0] RoundK0 = 32'h5A827999;
   localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
   localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
   localparam logic [31:0] RoundK3 = 32'hCA62C1D6;

   // One message beat after classification.
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  count;
      logic        last;
   } item_type;

   // Block hand-off control from the packer to the compression unit.
   typedef struct packed {
      logic valid;
      logic is_final;
   } dispatch_type;

   typedef logic [BlockWords-1:0][31:0] block_type;

endpackage

// ===== rtl/sha1he_front.sv =====
// Input stage: accept message beats, clamp the byte count, register the item.
module sha1he_front import sha1he_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [31:0] in_word,
   input  logic [2:0]  in_count,
   input  logic        in_last,
   output logic        out_valid,
   input  logic        out_ready,
   output item_type    out_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in      = 1'b1;
         item_in.word  = in_word;
         // counts above four mean a full word
         item_in.count = (in_count > MaxBytes) ? MaxBytes : in_count;
         item_in.last  = in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== rtl/sha1he_queue.sv =====
// Small FIFO that decouples the input stage from the block packer.
module sha1he_queue import sha1he_pkg::*; #(
   parameter int unsigned Depth = QueueDepthDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   item_type            mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                push, pop;

   assign in_ready  = (cnt_ff != CntFull);
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== rtl/sha1he_pack.sv =====
// Block packer: gather bytes into 64-byte blocks, add padding and length.
module sha1he_pack import sha1he_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   output logic         item_ready,
   input  item_type     item,
   input  logic         comp_ready,
   output dispatch_type dispatch,
   output block_type    block
);

   typedef enum logic {ST_DATA, ST_PAD} state_type;

   state_type                  state_ff, state_in;
   logic [BlockBytes-1:0][7:0] buf_ff, buf_in;
   logic [5:0]                 fill_ff, fill_in;
   logic [63:0]                bits_ff, bits_in;
   logic                       pad_done_ff, pad_done_in;

   logic [3:0][6:0]            pos;
   logic [3:0][7:0]            byte_of;
   logic [6:0]                 sum;
   logic                       crosses;
   logic                       pop;
   logic                       fits;
   logic [BlockBytes-1:0][7:0] merged_lo, merged_all, pad_bytes, out_bytes;

   assign sum     = {1'b0, fill_ff} + {4'b0, item.count};
   assign crosses = sum[6];
   assign fits    = (fill_ff < 6'(LengthBytePos));

   // byte lanes of the incoming word and where each one lands
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pos[k]     = {1'b0, fill_ff} + 7'(k);
         byte_of[k] = item.word[31 - 8*k -: 8];
      end
   end

   // merged_lo: block up to its end; merged_all also holds bytes spilling over
   always_comb begin
      merged_lo  = buf_ff;
      merged_all = buf_ff;
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < item.count) begin
            merged_all[pos[k][5:0]] = byte_of[k];
            if (!pos[k][6]) begin
               merged_lo[pos[k][5:0]] = byte_of[k];
            end
         end
      end
   end

   // pad block: held bytes, pad marker, zeros, then the length when it fits
   always_comb begin
      for (int j = 0; j < BlockBytes; j++) begin
         if (6'(j) < fill_ff) begin
            pad_bytes[j] = buf_ff[j];
         end else if ((6'(j) == fill_ff) && !pad_done_ff) begin
            pad_bytes[j] = PadByte;
         end else begin
            pad_bytes[j] = 8'h00;
         end
      end
      if (fits) begin
         for (int j = 0; j < 8; j++) begin
            pad_bytes[LengthBytePos + j] = bits_ff[63 - 8*j -: 8];
         end
      end
   end

   assign out_bytes = (state_ff == ST_DATA) ? merged_lo : pad_bytes;

   always_comb begin
      for (int i = 0; i < BlockWords; i++) begin
         block[i] = {out_bytes[4*i], out_bytes[4*i+1], out_bytes[4*i+2], out_bytes[4*i+3]};
      end
   end

   assign item_ready = (state_ff == ST_DATA) && (!crosses || comp_ready);
   assign pop        = item_valid && item_ready;

   always_comb begin
      state_in          = state_ff;
      buf_in            = buf_ff;
      fill_in           = fill_ff;
      bits_in           = bits_ff;
      pad_done_in       = pad_done_ff;
      dispatch.valid    = 1'b0;
      dispatch.is_final = 1'b0;
      unique case (state_ff)
         ST_DATA: begin
            if (pop) begin
               buf_in         = merged_all;
               fill_in        = sum[5:0];
               bits_in        = bits_ff + {58'b0, item.count, 3'b0};
               dispatch.valid = crosses;
               if (item.last) begin
                  state_in    = ST_PAD;
                  pad_done_in = 1'b0;
               end
            end
         end
         ST_PAD: begin
            if (comp_ready) begin
               dispatch.valid = 1'b1;
               fill_in        = '0;
               if (fits) begin
                  // length block out: clear for the next message
                  dispatch.is_final = 1'b1;
                  bits_in           = '0;
                  state_in          = ST_DATA;
               end else begin
                  // no room for the length: one more block, zeros and the length, follows
                  pad_done_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_DATA;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_DATA;
         fill_ff     <= '0;
         bits_ff     <= '0;
         pad_done_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         bits_ff     <= bits_in;
         pad_done_ff <= pad_done_in;
      end
      buf_ff <= buf_in;
   end

endmodule

// ===== rtl/sha1he_compress.sv =====
// Compression unit: 80 rounds, one per cycle, chaining and digest output.
module sha1he_compress import sha1he_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  dispatch_type dispatch,
   input  block_type    block,
   output logic         comp_ready,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [31:0]  out_word,
   output logic [2:0]   out_index,
   output logic         out_last
);

   typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINISH} state_type;

   state_type                    state_ff, state_in;
   logic [DigestWords-1:0][31:0] work_ff, work_in;
   logic [DigestWords-1:0][31:0] chain_ff, chain_in;
   logic [DigestWords-1:0][31:0] dig_ff, dig_in;
   block_type                    sched_ff, sched_in;
   logic [6:0]                   round_ff, round_in;
   logic                         final_ff, final_in;
   logic                         out_valid_ff, out_valid_in;
   logic [2:0]                   idx_ff, idx_in;

   logic [31:0] a, b, c, d, e, f, k, tmp, wx;
   logic [DigestWords-1:0][31:0] sum;

   assign a = work_ff[0];
   assign b = work_ff[1];
   assign c = work_ff[2];
   assign d = work_ff[3];
   assign e = work_ff[4];

   always_comb begin
      if (round_ff < Stage1End) begin
         f = (b & c) | (~b & d);
         k = RoundK0;
      end else if (round_ff < Stage2End) begin
         f = b ^ c ^ d;
         k = RoundK1;
      end else if (round_ff < Stage3End) begin
         f = (b & c) | (b & d) | (c & d);
         k = RoundK2;
      end else begin
         f = b ^ c ^ d;
         k = RoundK3;
      end
   end

   assign tmp = {a[26:0], a[31:27]} + f + e + k + sched_ff[0];
   assign wx  = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];

   always_comb begin
      for (int i = 0; i < DigestWords; i++) begin
         sum[i] = chain_ff[i] + work_ff[i];
      end
   end

   assign comp_ready = (state_ff == C_IDLE);

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      chain_in     = chain_ff;
      dig_in       = dig_ff;
      sched_in     = sched_ff;
      round_in     = round_ff;
      final_in     = final_ff;
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;

      // drain the digest one word per beat
      if (out_valid_ff && out_ready) begin
         for (int i = 0; i < DigestWords - 1; i++) begin
            dig_in[i] = dig_ff[i+1];
         end
         idx_in = idx_ff + 1'b1;
         if (idx_ff == LastDigestIdx) begin
            out_valid_in = 1'b0;
         end
      end

      unique case (state_ff)
         C_IDLE: begin
            if (dispatch.valid) begin
               work_in  = chain_ff;
               sched_in = block;
               round_in = '0;
               final_in = dispatch.is_final;
               state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            work_in[4] = d;
            work_in[3] = c;
            work_in[2] = {b[1:0], b[31:2]};
            work_in[1] = a;
            work_in[0] = tmp;
            for (int i = 0; i < BlockWords - 1; i++) begin
               sched_in[i] = sched_ff[i+1];
            end
            sched_in[BlockWords-1] = {wx[30:0], wx[31]};
            round_in = round_ff + 1'b1;
            if (round_ff == LastRound) begin
               state_in = C_FINISH;
            end
         end
         C_FINISH: begin
            if (!final_ff) begin
               chain_in = sum;
               state_in = C_IDLE;
            end else if (!out_valid_in) begin
               // hold until the previous digest has fully drained
               dig_in       = sum;
               idx_in       = '0;
               out_valid_in = 1'b1;
               chain_in     = InitHash;
               state_in     = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         chain_ff     <= InitHash;
         work_ff      <= '0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         work_ff      <= work_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
      dig_ff   <= dig_in;
      sched_ff <= sched_in;
      round_ff <= round_in;
      final_ff <= final_in;
   end

   assign out_valid = out_valid_ff;
   assign out_word  = dig_ff[0];
   assign out_index = idx_ff;
   assign out_last  = (idx_ff == LastDigestIdx);

endmodule

// ===== rtl/sha1_hash_engine_core.sv =====
// Top level of the streaming SHA-1 hash engine.
// Path: a beat passes the front register and the queue before the packer; each block goes
//   through the compression unit (load, 80 rounds, chaining add); five digest beats follow the last.
// Flow: the packer fills the next block during rounds; a beat that completes a block waits for the round unit.
// Last beat: one or two padding blocks before the digest, word 0 first.
// Reset: synchronous, active high; clears control and loads the initial hash.
module sha1_hash_engine_core import sha1he_pkg::*; #(
   parameter int unsigned QueueDepth = QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   // message beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [31:0] message_word, [34:32] bytes_valid, [39:35] zero
   input  logic        req_tlast,  // last_item
   // digest beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] digest_word, [34:32] word_index, [39:35] zero
   output logic        rsp_tlast   // final_word
);

   // front stage to queue
   logic         fr_valid, fr_ready;
   item_type     fr_item;
   // queue to packer
   logic         q_valid, q_ready;
   item_type     q_item;
   // packer to compression unit
   logic         comp_ready;
   dispatch_type dispatch;
   block_type    block;
   logic [31:0]  dig_word;
   logic [2:0]   dig_idx;

   // classify: clamp byte counts, register the beat
   sha1he_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_word   (req_tdata[31:0]),
      .in_count  (req_tdata[34:32]),
      .in_last   (req_tlast),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_item  (fr_item)
   );

   // decouple intake from block assembly so beats keep flowing during rounds
   sha1he_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_item   (fr_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   // gather bytes, hand off full blocks, pad and append the bit length
   sha1he_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .item       (q_item),
      .comp_ready (comp_ready),
      .dispatch   (dispatch),
      .block      (block)
   );

   // run rounds, chain the hash, drain the digest
   sha1he_compress u_compress (
      .clock      (clock),
      .reset      (reset),
      .dispatch   (dispatch),
      .block      (block),
      .comp_ready (comp_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_word   (dig_word),
      .out_index  (dig_idx),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, dig_idx, dig_word};

endmodule

// ===== test/tb_sha1_hash_engine_core.sv =====
// Self-checking testbench for sha1_hash_engine_core against a SHA-1 predictor.

class sha1_digest_tracker;
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        fin;
   } digest_beat_type;

   logic [31:0]     chain[sha1he_pkg::DigestWords];
   logic [31:0]     blk[16];
   logic [63:0]     bit_len;
   int unsigned     fill;
   digest_beat_type digest_due[$];
   int unsigned     errors;

   function new();
      load_iv();
      bit_len = '0;
      fill    = 0;
      errors  = 0;
      foreach (blk[i]) blk[i] = '0;
   endfunction

   function void load_iv();
      chain[0] = 32'h67452301;
      chain[1] = 32'hEFCDAB89;
      chain[2] = 32'h98BADCFE;
      chain[3] = 32'h10325476;
      chain[4] = 32'hC3D2E1F0;
   endfunction

   function logic [31:0] rotl(logic [31:0] x, int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Run the 80 rounds on the held block and fold the result into the chain.
   function void compress();
      logic [31:0] w[16];
      logic [31:0] a, b, c, d, e, f, k, tmp;
      int t;
      w = blk;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (t = 0; t < 80; t++) begin
         if (t >= 16)
            w[t & 15] = rotl(w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^ w[t & 15], 1);
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         tmp = rotl(a, 5) + f + e + k + w[t & 15];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = tmp;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endfunction

   function void put_byte(logic [7:0] v);
      int unsigned idx;
      int unsigned sh;
      idx = fill >> 2;
      sh  = (3 - (fill & 3)) * 8;
      if ((fill & 3) == 0)
         blk[idx] = {v, 24'h0};
      else
         blk[idx][sh +: 8] = v;
      fill++;
      if (fill == 64) begin
         compress();
         fill = 0;
      end
   endfunction

   // Absorb one accepted message beat; on the last beat, pad and queue the digest.
   function void note_beat(logic [31:0] word, logic [2:0] count, logic last);
      int unsigned n;
      int unsigned k;
      digest_beat_type beat;
      n = (count > 3'd4) ? 4 : count;
      for (k = 0; k < n; k++) begin
         put_byte(word[(31 - 8 * k) -: 8]);
         bit_len += 64'd8;
      end
      if (!last)
         return;
      put_byte(8'h80);
      while (fill != 56)
         put_byte(8'h00);
      blk[14] = bit_len[63:32];
      blk[15] = bit_len[31:0];
      compress();
      for (k = 0; k < sha1he_pkg::DigestWords; k++) begin
         beat.word  = chain[k];
         beat.index = 3'(k);
         beat.fin   = (k == sha1he_pkg::DigestWords - 1);
         digest_due.push_back(beat);
      end
      load_iv();
      bit_len = '0;
      fill    = 0;
   endfunction

   function void check_digest(logic [31:0] word, logic [2:0] index, logic fin);
      digest_beat_type want;
      if (digest_due.size() == 0) begin
         $display("%0t: unexpected digest beat %h index %0d last %b", $time, word, index, fin);
         errors++;
         return;
      end
      want = digest_due.pop_front();
      if (word !== want.word) begin
         $display("%0t: digest word: expected %h, got %h", $time, want.word, word);
         errors++;
      end
      if (index !== want.index) begin
         $display("%0t: word index: expected %0d, got %0d", $time, want.index, index);
         errors++;
      end
      if (fin !== want.fin) begin
         $display("%0t: final flag: expected %b, got %b", $time, want.fin, fin);
         errors++;
      end
   endfunction

   function int unsigned pending();
      return digest_due.size();
   endfunction
endclass

module tb_sha1_hash_engine_core;
   import sha1he_pkg::*;

   localparam int unsigned StallLimit = 4000;  // cycles without any accepted beat
   localparam int unsigned LongHold   = 600;   // receiver hold-off to back the block up
   localparam int unsigned TargetBeats = 350;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   sha1_digest_tracker digests = new();

   logic        quiet = 1'b0;      // no gaps on either side while set
   logic        long_hold = 1'b0;  // ask the receiver for one long hold-off
   int unsigned hold_left = 0;
   int unsigned stall_cycles = 0;
   int unsigned beats_sent = 0;

   sha1_hash_engine_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one; none at all in a quiet stretch.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one beat, hold it until accepted, then idle for a random gap.
   task automatic send_beat(logic [31:0] word, logic [2:0] count, logic last);
      int unsigned gap;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {5'b0, count, word};
      req_tlast  = last;
      do
         @(posedge clock);
      while (!req_tready);
      digests.note_beat(word, count, last);
      beats_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         req_tdata  = {5'b0, 3'($urandom), $urandom};  // noise while idle
         req_tlast  = 1'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Send a message of full words with the odd short or oversized count mixed in.
   task automatic send_message(int unsigned words, logic [2:0] tail_count);
      int unsigned i;
      int unsigned r;
      logic [2:0] count;
      for (i = 0; i < words; i++) begin
         r = $urandom_range(0, 19);
         if (r == 0)
            count = 3'($urandom_range(0, 3));
         else if (r == 1)
            count = 3'($urandom_range(5, 7));
         else
            count = 3'd4;
         send_beat($urandom, count, 1'b0);
      end
      send_beat($urandom, tail_count, 1'b1);
   endtask

   // Drop the offer so no beat goes in twice, then wait for every digest.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (digests.pending() != 0)
         @(posedge clock);
   endtask

   // Receiver: decide readiness at the falling edge, count hold-offs here.
   always @(negedge clock) begin
      if (long_hold && hold_left == 0) begin
         hold_left = LongHold;
         long_hold = 1'b0;
      end
      if (hold_left != 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         int unsigned gap;
         gap = pick_gap();
         if (gap == 0) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = 1'b0;
            hold_left  = gap - 1;
         end
      end
   end

   // Check every accepted digest beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         digests.check_digest(rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
   end

   // Watchdog: end the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= StallLimit) begin
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int unsigned i;
      int unsigned r;
      int unsigned words;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty message, "abc", all-zero and all-one words.
      send_beat(32'h0000_0000, 3'd0, 1'b1);
      send_beat(32'h6162_6300, 3'd3, 1'b1);
      send_beat(32'h0000_0000, 3'd4, 1'b0);
      send_beat(32'hFFFF_FFFF, 3'd4, 1'b1);
      // Oversized counts clamp to four bytes.
      send_beat(32'hFFFF_FFFF, 3'd7, 1'b0);
      send_beat(32'h0123_4567, 3'd5, 1'b0);
      send_beat(32'h89AB_CDEF, 3'd6, 1'b1);
      // Short words in mid-message pack without gaps.
      send_beat(32'hA1B2_C3D4, 3'd1, 1'b0);
      send_beat(32'h1122_3344, 3'd2, 1'b0);
      send_beat(32'h5566_7788, 3'd3, 1'b1);
      // 56 bytes: length no longer fits, so padding spills into a second block.
      for (i = 0; i < 13; i++)
         send_beat($urandom, 3'd4, 1'b0);
      send_beat($urandom, 3'd4, 1'b1);

      // Pause the sender until every digest is out.
      wait_drained();

      // Hold the receiver off while short messages pile up, back to back.
      long_hold = 1'b1;
      quiet = 1'b1;
      for (i = 0; i < 10; i++)
         send_message($urandom_range(0, 2), 3'($urandom_range(0, 7)));
      quiet = 1'b0;
      wait_drained();

      // Random messages: mostly short, some spanning a few blocks, a rare long one.
      while (beats_sent < TargetBeats) begin
         quiet = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 70)
            words = $urandom_range(0, 15);
         else if (r < 95)
            words = $urandom_range(16, 40);
         else
            words = $urandom_range(50, 100);
         if (words > TargetBeats - beats_sent)
            words = TargetBeats - beats_sent;
         send_message(words, 3'($urandom_range(0, 7)));
         if ($urandom_range(0, 11) == 0)
            wait_drained();
      end
      quiet = 1'b0;

      @(negedge clock);
      req_tvalid = 1'b0;
      wait_drained();
      repeat (200) @(posedge clock);
      if (digests.errors == 0 && digests.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
